// File: src/pool_connection_selector_defines.svh
// assertion macros shared by the checker
`ifndef POOL_CONNECTION_SELECTOR_DEFINES_SVH
`define POOL_CONNECTION_SELECTOR_DEFINES_SVH

// property that holds outside reset
`define PCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequence checked in the cycle after the trigger
`define PCS_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) trig |=> prop) else $error(msg);

`endif

// File: src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// types and codes of the connection selector
// ----------------------------------------------------------------------------
package pcs_pkg;
	localparam int NUM_SLOTS = 16;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_REMOVE = 3'd1, OP_REQ_ADD = 3'd2,
		OP_REQ_DEL = 3'd3, OP_CHOOSE = 3'd4, OP_CLOSE = 3'd5,
		OP_NONE6 = 3'd6, OP_NONE7 = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		PH_ACT_AWAIT = 3'd0, PH_ACTIVE = 3'd1, PH_CLOS_AWAIT = 3'd2,
		PH_NEXT_TRY = 3'd3, PH_CLOSING = 3'd4, PH_BAD5 = 3'd5,
		PH_BAD6 = 3'd6, PH_BAD7 = 3'd7
	} phase_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_CLOSING = 2'd2;

	localparam int CFG_CONNS = 0;
	localparam int CFG_DELAY = 1;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_SCAN, S_DECIDE, S_WRITE, S_OUT
	} state_t;
endpackage

// File: src/pool_connection_selector.sv
// flow: single-slot ops go S_READ, S_DECIDE, S_WRITE, S_OUT; choose and close scan after S_READ
// throughput: one request at a time; the scan reads the slot memory one entry per cycle through its read port
// reset: all slots free, conns_per_server 4, idle-close delay 0
// ----------------------------------------------------------------------------
// pool_connection_selector
// connection slot table with choose and idle-close operations
// ----------------------------------------------------------------------------
module pool_connection_selector #(
	parameter int SERVER_BITS = 8,
	parameter int LOAD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             req_type,
	input  logic [SERVER_BITS-1:0] server_id,
	input  logic [4:0]             connection_id,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [4:0]             chosen_connection,
	output logic signed [16:0]     close_result
);
	import pcs_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	typedef struct packed {
		logic [SERVER_BITS-1:0] srv;
		logic [LOAD_BITS-1:0]   load;
		phase_t                 ph;
	} entry_t;

	entry_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;

	state_t state_q, state_d;
	logic [4:0] conns_q;
	logic [15:0] delay_q;

	op_t op_q;
	logic [SERVER_BITS-1:0] srv_q;
	logic in_range_q;
	logic [IW-1:0] slot_q;
	entry_t self_q;
	logic self_valid_q;

	// scan pipeline
	logic [CW-1:0] rcnt_q;
	logic [IW-1:0] raddr;
	logic          rd_en;
	entry_t        rdata_s1;
	logic [IW-1:0] ridx_s1;
	logic          rv_s1;
	logic          self_s1;

	logic [CW-1:0] held_q;
	logic          pick_q, done_q, other_q, awaiting_q, busy_q;
	logic [IW-1:0] pick_idx_q;
	logic [LOAD_BITS-1:0] best_q;

	logic          wr_en;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	logic          set_valid, clr_valid;

	logic [1:0]  st_q;
	logic [4:0]  ch_q;
	logic signed [16:0] cr_q;
	logic [1:0]  st_d;
	logic [4:0]  ch_d;
	logic signed [16:0] cr_d;

	logic wr_q_r, set_q_r, clr_q_r, choose_q_r;
	logic [IW-1:0] waddr_q_r;
	entry_t wdata_q_r;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign chosen_connection = ch_q;
	assign close_result = cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conns_q <= 5'd4;
			delay_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == 1'(CFG_CONNS)) conns_q <= cfg_data[4:0];
			else delay_q <= cfg_data;
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (set_valid) valid_q[waddr] <= 1'b1;
		else if (clr_valid) valid_q[slot_q] <= 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_READ;
			S_READ: begin
				if (op_q == OP_CHOOSE || op_q == OP_CLOSE) state_d = S_SCAN;
				else state_d = S_DECIDE;
			end
			S_SCAN: if (rcnt_q == CW'(NUM_SLOTS) && !rv_s1) state_d = S_DECIDE;
			S_DECIDE: state_d = S_WRITE;
			S_WRITE: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// read addressing: self slot in S_READ, then sweep
	always_comb begin
		rd_en = 1'b0;
		raddr = slot_q;
		if (state_q == S_READ) rd_en = 1'b1;
		else if (state_q == S_SCAN && rcnt_q < CW'(NUM_SLOTS)) begin
			rd_en = 1'b1;
			raddr = rcnt_q[IW-1:0];
		end
	end

	logic cid_ok;
	assign cid_ok = (connection_id != 5'd0) && ({27'd0, connection_id} <= 32'(NUM_SLOTS));

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= op_t'(req_type);
			srv_q <= server_id;
			in_range_q <= cid_ok;
			slot_q <= IW'(connection_id - 5'd1);
		end
		if (self_s1) begin
			self_q <= rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			rv_s1 <= 1'b0;
			self_s1 <= 1'b0;
			ridx_s1 <= '0;
		end else begin
			rv_s1 <= (state_q == S_SCAN) && rd_en;
			self_s1 <= (state_q == S_READ);
			if (state_q == S_READ) rcnt_q <= '0;
			else if (state_q == S_SCAN && rd_en) rcnt_q <= rcnt_q + CW'(1);
			ridx_s1 <= raddr;
		end
	end

	// self entry is captured the cycle after S_READ
	entry_t self_e;
	assign self_e = self_s1 ? rdata_s1 : self_q;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) self_valid_q <= in_range_q && valid_q[slot_q];
	end

	// scan accumulation
	logic [SERVER_BITS-1:0] cmp_srv;
	assign cmp_srv = (op_q == OP_CHOOSE) ? srv_q : self_q.srv;
	logic mt;
	assign mt = rv_s1 && valid_q[ridx_s1] && rdata_s1.srv == cmp_srv;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			held_q <= '0; pick_q <= 1'b0; done_q <= 1'b0;
			other_q <= 1'b0; awaiting_q <= 1'b0; busy_q <= 1'b0;
			best_q <= '0; pick_idx_q <= '0;
		end else if (state_q == S_SCAN && mt) begin
			held_q <= held_q + CW'(1);
			if (ridx_s1 != slot_q) begin
				other_q <= 1'b1;
				if (rdata_s1.ph == PH_CLOS_AWAIT) awaiting_q <= 1'b1;
			end
			if (rdata_s1.ph == PH_ACTIVE || rdata_s1.ph == PH_ACT_AWAIT) busy_q <= 1'b1;
			if (!done_q && rdata_s1.ph != PH_CLOSING) begin
				if (rdata_s1.load == '0) begin
					pick_q <= 1'b1; pick_idx_q <= ridx_s1;
					best_q <= '0; done_q <= 1'b1;
				end else if (!pick_q || rdata_s1.load < best_q) begin
					pick_q <= 1'b1; pick_idx_q <= ridx_s1; best_q <= rdata_s1.load;
				end
			end
		end
	end

	// decide results and write-back
	entry_t wdata_d;
	logic   wr_d, set_d, clr_d;
	logic [IW-1:0] waddr_d;
	always_comb begin
		st_d = ST_OK; ch_d = '0; cr_d = '0;
		wdata_d = self_e; wr_d = 1'b0; set_d = 1'b0; clr_d = 1'b0; waddr_d = slot_q;
		unique case (op_q)
			OP_ADD: if (in_range_q && !self_valid_q) begin
				wdata_d.srv = srv_q; wdata_d.load = '0; wdata_d.ph = PH_ACT_AWAIT;
				wr_d = 1'b1; set_d = 1'b1;
			end
			OP_REMOVE: if (self_valid_q) clr_d = 1'b1; else st_d = ST_UNKNOWN;
			OP_REQ_ADD: if (self_valid_q) begin
				if (self_e.load != LOAD_MAX) wdata_d.load = self_e.load + 1'b1;
				wdata_d.ph = PH_ACTIVE; wr_d = 1'b1;
			end else st_d = ST_UNKNOWN;
			OP_REQ_DEL: if (self_valid_q) begin
				if (self_e.load != '0) wdata_d.load = self_e.load - 1'b1;
				wr_d = 1'b1;
			end else st_d = ST_UNKNOWN;
			OP_CHOOSE: if (pick_q && ({{(32-CW){1'b0}}, held_q} >= {27'd0, conns_q}
					|| best_q == '0)) begin
				ch_d = 5'(pick_idx_q) + 5'd1;
				waddr_d = pick_idx_q; wr_d = 1'b1;
			end
			OP_CLOSE: begin
				cr_d = -17'sd1;
				if (!self_valid_q) st_d = ST_UNKNOWN;
				else unique case (self_e.ph)
					PH_CLOSING: st_d = ST_CLOSING;
					PH_NEXT_TRY: begin
						wdata_d.ph = PH_CLOSING; wr_d = 1'b1; cr_d = '0;
					end
					PH_ACTIVE: if (self_e.load == '0) begin
						wr_d = 1'b1;
						if ((other_q && awaiting_q) || delay_q == '0) begin
							wdata_d.ph = PH_CLOSING; cr_d = '0;
						end else begin
							wdata_d.ph = PH_CLOS_AWAIT; cr_d = {1'b0, delay_q};
						end
					end
					PH_CLOS_AWAIT: begin
						cr_d = {1'b0, delay_q};
						if (!busy_q) begin wdata_d.ph = PH_NEXT_TRY; wr_d = 1'b1; end
					end
					default: cr_d = -17'sd1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			st_q <= st_d; ch_q <= ch_d; cr_q <= cr_d;
			wr_q_r <= wr_d; set_q_r <= set_d; clr_q_r <= clr_d;
			waddr_q_r <= waddr_d; wdata_q_r <= wdata_d;
			choose_q_r <= (op_q == OP_CHOOSE);
		end
	end

	// track the entry that becomes the pick as the scan goes
	entry_t pick_hold_q;
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && mt && !done_q && rdata_s1.ph != PH_CLOSING &&
				(rdata_s1.load == '0 || !pick_q || rdata_s1.load < best_q))
			pick_hold_q <= rdata_s1;
	end

	always_comb begin
		wr_en = (state_q == S_WRITE) && wr_q_r;
		set_valid = (state_q == S_WRITE) && set_q_r;
		clr_valid = (state_q == S_WRITE) && clr_q_r;
		waddr = (state_q == S_WRITE) ? waddr_q_r : slot_q;
		wdata = wdata_q_r;
		if (choose_q_r) begin
			wdata = pick_hold_q;
			wdata.ph = PH_ACT_AWAIT;
		end
	end
endmodule

// File: src/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// port-level checks of the connection selector
// ----------------------------------------------------------------------------
`include "pool_connection_selector_defines.svh"
module pcs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready,
	input logic [1:0] status,
	input logic [4:0] chosen_connection
);
	import pcs_pkg::*;

	`PCS_ASSERT(a_no_in_while_out, out_valid |-> !in_ready, "request taken while result pending")
	`PCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped")
	`PCS_ASSERT(a_status_range, out_valid |-> status != 2'd3, "bad status")
	`PCS_ASSERT(a_cfg_idle, cfg_ready |-> in_ready, "config port open while busy")
	`PCS_ASSERT(a_chosen_ok, out_valid && chosen_connection != '0 |-> status == ST_OK, "bad pick")
endmodule

bind pool_connection_selector pcs_checker u_pcs_checker (.*);
